// File: sv/ssme_pkg.sv
// shared types and constants for the sorted set merge engine
// no dependencies; imported by ssme_ctrl, ssme_dp and the top level
`timescale 1ns / 1ps

package ssme_pkg;

    localparam int SET_DEPTH   = 16;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(SET_DEPTH + 1);
    localparam int IDX_W       = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);
    localparam int ELEM_W      = 32;

    typedef enum logic [1:0] {
        FUNC_LOAD_A = 2'd0,
        FUNC_LOAD_B = 2'd1,
        FUNC_RUN    = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        OP_UNION     = 2'd0,
        OP_INTERSECT = 2'd1,
        OP_DIFF      = 2'd2
    } t_set_op;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_MERGE = 1'b1
    } t_state;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
    } t_dp_status;

endpackage

// File: sv/ssme_ctrl.sv
// controller for the sorted set merge engine: accepts load and run beats
// depends on ssme_pkg
`timescale 1ns / 1ps

module ssme_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [1:0]          i_func,
    input  ssme_pkg::t_dp_status i_status,
    output ssme_pkg::t_dp_cmd   o_cmd,
    output logic                busy
);
    import ssme_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_func)
                        FUNC_LOAD_A: o_cmd.load_a = 1'b1;
                        FUNC_LOAD_B: o_cmd.load_b = 1'b1;
                        FUNC_RUN:    n_state = ST_MERGE;
                        default:     ;
                    endcase
                end
            end
            ST_MERGE: begin
                o_cmd.step = 1'b1;
                if (i_status.done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

    a_idle_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !o_cmd.step)
        else $error("merge step issued while idle");

    a_run_enters_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_RUN) |=> busy)
        else $error("run beat did not start a merge");

    a_done_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_status.done) |=> !busy)
        else $error("controller stayed busy after merge end");

endmodule

// File: sv/ssme_dp.sv
// datapath for the sorted set merge engine: set stores, counts, merge
// compare, pending result and output registers; depends on ssme_pkg
`timescale 1ns / 1ps

module ssme_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ssme_pkg::t_dp_cmd                i_cmd,
    output ssme_pkg::t_dp_status             o_status,
    input  logic signed [ssme_pkg::ELEM_W-1:0] i_element_value,
    input  logic                             i_cfg_valid,
    input  logic [1:0]                       i_cfg_data,
    output logic                             o_cfg_ready,
    output logic                             o_result_valid,
    output logic signed [ssme_pkg::ELEM_W-1:0] o_result_value,
    output logic                             o_result_last,
    output logic                             o_result_empty,
    output logic                             o_load_overflowed
);
    import ssme_pkg::*;

    logic signed [ELEM_W-1:0] mem_a [SET_DEPTH];
    logic signed [ELEM_W-1:0] mem_b [SET_DEPTH];

    logic signed [ELEM_W-1:0] r_a_rd;
    logic signed [ELEM_W-1:0] r_b_rd;
    logic [CNT_W-1:0]  r_cnt_a;
    logic [CNT_W-1:0]  r_cnt_b;
    logic              r_ovf;
    t_set_op           r_op;
    logic [CNT_W-1:0]  r_ia;
    logic [CNT_W-1:0]  r_ib;
    logic [CNT_W-1:0]  n_ia;
    logic [CNT_W-1:0]  n_ib;
    logic [EMIT_W-1:0] r_emit_cnt;
    logic              r_pend_valid;
    logic signed [ELEM_W-1:0] r_pend_value;

    logic              r_out_valid;
    logic signed [ELEM_W-1:0] r_out_value;
    logic              r_out_last;
    logic              r_out_empty;
    logic              r_out_ovf;
    logic              n_out_valid;
    logic signed [ELEM_W-1:0] n_out_value;
    logic              n_out_last;
    logic              n_out_empty;

    logic a_ok;
    logic b_ok;
    logic a_lt_b;
    logic b_lt_a;
    logic adv_a;
    logic adv_b;
    logic emit;
    logic done;
    logic emit_go;
    logic signed [ELEM_W-1:0] emit_val;
    logic full_a;
    logic full_b;

    assign o_cfg_ready = 1'b1;

    assign full_a = (r_cnt_a == CNT_W'(SET_DEPTH));
    assign full_b = (r_cnt_b == CNT_W'(SET_DEPTH));

    // merge decision from the registered heads of both sets
    always_comb begin
        a_ok     = (r_ia < r_cnt_a);
        b_ok     = (r_ib < r_cnt_b);
        a_lt_b   = (r_a_rd < r_b_rd);
        b_lt_a   = (r_b_rd < r_a_rd);
        adv_a    = 1'b0;
        adv_b    = 1'b0;
        emit     = 1'b0;
        emit_val = r_a_rd;
        done     = 1'b0;
        case (r_op)
            OP_UNION: begin
                if (a_ok && b_ok) begin
                    emit = 1'b1;
                    if (a_lt_b) begin
                        adv_a = 1'b1;
                    end else if (b_lt_a) begin
                        adv_b    = 1'b1;
                        emit_val = r_b_rd;
                    end else begin
                        adv_a = 1'b1;
                        adv_b = 1'b1;
                    end
                end else if (a_ok) begin
                    emit  = 1'b1;
                    adv_a = 1'b1;
                end else if (b_ok) begin
                    emit     = 1'b1;
                    adv_b    = 1'b1;
                    emit_val = r_b_rd;
                end else begin
                    done = 1'b1;
                end
            end
            OP_INTERSECT: begin
                if (a_ok && b_ok) begin
                    if (a_lt_b) begin
                        adv_a = 1'b1;
                    end else if (b_lt_a) begin
                        adv_b = 1'b1;
                    end else begin
                        emit  = 1'b1;
                        adv_a = 1'b1;
                        adv_b = 1'b1;
                    end
                end else begin
                    done = 1'b1;
                end
            end
            OP_DIFF: begin
                if (a_ok && b_ok) begin
                    if (a_lt_b) begin
                        emit  = 1'b1;
                        adv_a = 1'b1;
                    end else if (b_lt_a) begin
                        adv_b = 1'b1;
                    end else begin
                        adv_a = 1'b1;
                        adv_b = 1'b1;
                    end
                end else if (a_ok) begin
                    emit  = 1'b1;
                    adv_a = 1'b1;
                end else begin
                    done = 1'b1;
                end
            end
            default: done = 1'b1;
        endcase
    end

    assign o_status.done = done;

    // pointers rest at zero while idle so the first heads are read ahead
    always_comb begin
        if (i_cmd.step && !done) begin
            n_ia = r_ia + CNT_W'(adv_a);
            n_ib = r_ib + CNT_W'(adv_b);
        end else begin
            n_ia = '0;
            n_ib = '0;
        end
    end

    assign emit_go = i_cmd.step && emit && (r_emit_cnt != EMIT_W'(MAX_RESULTS));

    // one result is held back so the last one can be flagged
    always_comb begin
        n_out_valid = 1'b0;
        n_out_value = r_pend_value;
        n_out_last  = 1'b0;
        n_out_empty = 1'b0;
        if (i_cmd.step && done) begin
            n_out_valid = 1'b1;
            n_out_last  = 1'b1;
            if (!r_pend_valid) begin
                n_out_empty = 1'b1;
                n_out_value = '0;
            end
        end else if (emit_go && r_pend_valid) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && !full_a) begin
            mem_a[r_cnt_a[IDX_W-1:0]] <= i_element_value;
        end
        if (i_cmd.load_b && !full_b) begin
            mem_b[r_cnt_b[IDX_W-1:0]] <= i_element_value;
        end
        r_a_rd <= mem_a[n_ia[IDX_W-1:0]];
        r_b_rd <= mem_b[n_ib[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_pend_value <= emit_val;
        end
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
        r_out_ovf   <= r_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_ovf        <= 1'b0;
            r_op         <= OP_UNION;
            r_ia         <= '0;
            r_ib         <= '0;
            r_emit_cnt   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_ia        <= n_ia;
            r_ib        <= n_ib;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_op <= t_set_op'(i_cfg_data);
            end
            if (i_cmd.load_a) begin
                if (full_a) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt_a <= r_cnt_a + CNT_W'(1);
                end
            end
            if (i_cmd.load_b) begin
                if (full_b) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt_b <= r_cnt_b + CNT_W'(1);
                end
            end
            if (emit_go) begin
                r_pend_valid <= 1'b1;
                r_emit_cnt   <= r_emit_cnt + EMIT_W'(1);
            end
            // end of run consumes both sets
            if (i_cmd.step && done) begin
                r_cnt_a      <= '0;
                r_cnt_b      <= '0;
                r_ovf        <= 1'b0;
                r_pend_valid <= 1'b0;
                r_emit_cnt   <= '0;
            end
        end
    end

    assign o_result_valid    = r_out_valid;
    assign o_result_value    = r_out_value;
    assign o_result_last     = r_out_last;
    assign o_result_empty    = r_out_empty;
    assign o_load_overflowed = r_out_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CNT_W'(SET_DEPTH)) && (r_cnt_b <= CNT_W'(SET_DEPTH)))
        else $error("set count beyond depth");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result_empty) |-> o_result_last)
        else $error("empty result not flagged last");

    a_done_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && done) |=> (o_result_valid && o_result_last))
        else $error("run ended without a last beat");

    a_pend_before_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit_cnt != '0) |-> r_pend_valid)
        else $error("emit count without a held result");

endmodule

// File: sv/sorted_set_merge_engine_top.sv
// load beats keep busy low; a run holds busy until the merge ends, one merge
// step per cycle through the store read and compare loop; each result beat is
// registered and leaves in the cycle after the step that releases it, the last
// one in the same cycle that busy falls. one item per run minimum.
// synchronous active-low reset clears counts, overflow flag, mode and control;
// the set stores are not cleared. results cannot be stalled by the receiver
`timescale 1ns / 1ps

module sorted_set_merge_engine_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_func,
    input  logic signed [ssme_pkg::ELEM_W-1:0] i_element_value,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_data,
    output logic                               o_result_valid,
    output logic signed [ssme_pkg::ELEM_W-1:0] o_result_value,
    output logic                               o_result_last,
    output logic                               o_result_empty,
    output logic                               o_load_overflowed
);
    import ssme_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    ssme_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_func   (i_func),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    ssme_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_element_value   (i_element_value),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .o_cfg_ready       (o_cfg_ready),
        .o_result_valid    (o_result_valid),
        .o_result_value    (o_result_value),
        .o_result_last     (o_result_last),
        .o_result_empty    (o_result_empty),
        .o_load_overflowed (o_load_overflowed)
    );

endmodule
